### rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, ignored while reset is held
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ntaf_pkg.sv
// types, constants and helper functions of the number to ascii formatter
package ntaf_pkg;

    // input word: request kind and the number to print
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
    } t_in_word;

    // output word: one character and the end-of-run flag
    typedef struct packed {
        logic [7:0] ascii_byte;
        logic       last;
    } t_out_word;

    // request kinds
    typedef enum logic [1:0] {
        K_CHAR   = 2'd0,
        K_DEC    = 2'd1,
        K_HEXMIN = 2'd2,
        K_HEX8   = 2'd3
    } t_kind;

    // classified request as it sits in the queue
    typedef struct packed {
        t_kind       kind;
        logic        is_lf;
        logic [31:0] value;
    } t_task;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_CHAR   = 3'd1,
        ST_CR     = 3'd2,
        ST_PFX0   = 3'd3,
        ST_PFXX   = 3'd4,
        ST_CONV   = 3'd5,
        ST_DIGITS = 3'd6
    } t_state;

    // widths and counts
    localparam int BIN_BITS   = 32;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int NIB_BITS   = 4;
    localparam int BUF_BITS   = DEC_DIGITS * NIB_BITS;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);

    // character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_A_OFF = 8'h37;

    // nibble to uppercase hex character
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CH_ZERO + {4'h0, nib};
        end
        return CH_A_OFF + {4'h0, nib};
    endfunction

    // shift-add-3 correction on every bcd digit
    function automatic logic [BUF_BITS-1:0] bcd_adjust(input logic [BUF_BITS-1:0] bcd);
        logic [BUF_BITS-1:0] res;
        res = bcd;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (bcd[NIB_BITS*i +: NIB_BITS] >= 4'd5) begin
                res[NIB_BITS*i +: NIB_BITS] = bcd[NIB_BITS*i +: NIB_BITS] + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

### rtl/core/ntaf_front.sv
// front end: accepts requests, classifies them and queues them for the back end
module ntaf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ntaf_pkg::t_in_word i_word,
    output logic              o_stall,
    output logic              o_task_valid,
    output ntaf_pkg::t_task   o_task,
    input  logic              i_task_pop
);

    ntaf_pkg::t_task                  r_mem [ntaf_pkg::QDEPTH];
    logic [ntaf_pkg::QPTR_W-1:0]      r_wptr, n_wptr;
    logic [ntaf_pkg::QPTR_W-1:0]      r_rptr, n_rptr;
    logic [ntaf_pkg::QPTR_W:0]        r_count, n_count;
    ntaf_pkg::t_task                  w_class;
    logic                             w_push;
    logic                             w_pop;

    // classify the incoming word
    always_comb begin
        w_class.kind  = ntaf_pkg::t_kind'(i_word.kind);
        w_class.value = i_word.value;
        w_class.is_lf = 1'b0;
        if (w_class.kind == ntaf_pkg::K_CHAR) begin
            w_class.value = {24'h0, i_word.value[7:0]};
            w_class.is_lf = (i_word.value[7:0] == ntaf_pkg::CH_LF);
        end
    end

    // queue control
    assign o_stall      = (r_count == (ntaf_pkg::QPTR_W+1)'(ntaf_pkg::QDEPTH));
    assign o_task_valid = (r_count != '0);
    assign o_task       = r_mem[r_rptr];
    assign w_push       = i_valid && !o_stall;
    assign w_pop        = i_task_pop && o_task_valid;

    always_comb begin
        n_wptr  = r_wptr + (ntaf_pkg::QPTR_W)'(w_push);
        n_rptr  = r_rptr + (ntaf_pkg::QPTR_W)'(w_pop);
        n_count = r_count + (ntaf_pkg::QPTR_W+1)'(w_push) - (ntaf_pkg::QPTR_W+1)'(w_pop);
    end

    // pointer and fill registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_class;
        end
    end

endmodule

### rtl/core/ntaf_back.sv
// back end: turns one queued request into its run of characters
module ntaf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_task_valid,
    input  ntaf_pkg::t_task    i_task,
    output logic               o_task_pop,
    output logic               o_valid,
    output ntaf_pkg::t_out_word o_word,
    input  logic               i_stall
);

    ntaf_pkg::t_state                 r_state, n_state;
    logic [ntaf_pkg::BUF_BITS-1:0]    r_digits, n_digits;
    logic [ntaf_pkg::BIN_BITS-1:0]    r_bin, n_bin;
    logic [4:0]                       r_cnt, n_cnt;
    logic [3:0]                       r_left, n_left;
    logic                             r_started, n_started;
    logic                             r_suppress, n_suppress;
    logic [7:0]                       r_char, n_char;
    logic                             r_lf, n_lf;
    logic                             r_out_valid, n_out_valid;
    ntaf_pkg::t_out_word              r_out, n_out;
    logic                             w_free;
    logic                             w_emit;
    logic [3:0]                       w_nib;
    logic [ntaf_pkg::BUF_BITS-1:0]    w_adj;

    assign w_free = !r_out_valid || !i_stall;
    assign w_nib  = r_digits[ntaf_pkg::BUF_BITS-1 -: ntaf_pkg::NIB_BITS];
    assign w_adj  = ntaf_pkg::bcd_adjust(r_digits);

    // sequencer: next state and character selection
    always_comb begin
        n_state    = r_state;
        n_digits   = r_digits;
        n_bin      = r_bin;
        n_cnt      = r_cnt;
        n_left     = r_left;
        n_started  = r_started;
        n_suppress = r_suppress;
        n_char     = r_char;
        n_lf       = r_lf;
        n_out      = r_out;
        w_emit     = 1'b0;
        o_task_pop = 1'b0;
        unique case (r_state)
            ntaf_pkg::ST_IDLE: begin
                if (i_task_valid) begin
                    o_task_pop = 1'b1;
                    n_started  = 1'b0;
                    n_left     = 4'(ntaf_pkg::HEX_DIGITS - 1);
                    n_digits   = {i_task.value, 8'h00};
                    unique case (i_task.kind)
                        ntaf_pkg::K_CHAR: begin
                            n_char  = i_task.value[7:0];
                            n_lf    = i_task.is_lf;
                            n_state = ntaf_pkg::ST_CHAR;
                        end
                        ntaf_pkg::K_DEC: begin
                            n_bin      = i_task.value;
                            n_digits   = '0;
                            n_cnt      = 5'(ntaf_pkg::BIN_BITS - 1);
                            n_left     = 4'(ntaf_pkg::DEC_DIGITS - 1);
                            n_suppress = 1'b1;
                            n_state    = ntaf_pkg::ST_CONV;
                        end
                        ntaf_pkg::K_HEXMIN: begin
                            n_suppress = 1'b1;
                            n_state    = ntaf_pkg::ST_PFX0;
                        end
                        ntaf_pkg::K_HEX8: begin
                            n_suppress = 1'b0;
                            n_state    = ntaf_pkg::ST_DIGITS;
                        end
                    endcase
                end
            end
            ntaf_pkg::ST_CHAR: begin
                if (w_free) begin
                    w_emit  = 1'b1;
                    n_out   = '{ascii_byte: r_char, last: !r_lf};
                    n_state = r_lf ? ntaf_pkg::ST_CR : ntaf_pkg::ST_IDLE;
                end
            end
            ntaf_pkg::ST_CR: begin
                if (w_free) begin
                    w_emit  = 1'b1;
                    n_out   = '{ascii_byte: ntaf_pkg::CH_CR, last: 1'b1};
                    n_state = ntaf_pkg::ST_IDLE;
                end
            end
            ntaf_pkg::ST_PFX0: begin
                if (w_free) begin
                    w_emit  = 1'b1;
                    n_out   = '{ascii_byte: ntaf_pkg::CH_ZERO, last: 1'b0};
                    n_state = ntaf_pkg::ST_PFXX;
                end
            end
            ntaf_pkg::ST_PFXX: begin
                if (w_free) begin
                    w_emit  = 1'b1;
                    n_out   = '{ascii_byte: ntaf_pkg::CH_X, last: 1'b0};
                    n_state = ntaf_pkg::ST_DIGITS;
                end
            end
            ntaf_pkg::ST_CONV: begin
                // one shift-add-3 step per cycle, msb of the binary first
                n_digits = {w_adj[ntaf_pkg::BUF_BITS-2:0], r_bin[ntaf_pkg::BIN_BITS-1]};
                n_bin    = {r_bin[ntaf_pkg::BIN_BITS-2:0], 1'b0};
                n_cnt    = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = ntaf_pkg::ST_DIGITS;
                end
            end
            ntaf_pkg::ST_DIGITS: begin
                if (r_suppress && !r_started && (w_nib == '0) && (r_left != '0)) begin
                    // leading zero, drop it
                    n_digits = r_digits << ntaf_pkg::NIB_BITS;
                    n_left   = r_left - 4'd1;
                end else if (w_free) begin
                    w_emit    = 1'b1;
                    n_out     = '{ascii_byte: ntaf_pkg::hex_char(w_nib), last: (r_left == '0)};
                    n_started = 1'b1;
                    n_digits  = r_digits << ntaf_pkg::NIB_BITS;
                    n_left    = r_left - 4'd1;
                    if (r_left == '0) begin
                        n_state = ntaf_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ntaf_pkg::ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ntaf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_digits   <= n_digits;
        r_bin      <= n_bin;
        r_cnt      <= n_cnt;
        r_left     <= n_left;
        r_started  <= n_started;
        r_suppress <= n_suppress;
        r_char     <= n_char;
        r_lf       <= n_lf;
        r_out      <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

### rtl/core/number_to_ascii_formatter.sv
// top level of the number to ascii formatter: request queue and character sequencer
//
//  channel  dir  payload                       handshake
//  request  in   i_word {kind, value}          i_valid / o_stall
//  text     out  o_word {ascii_byte, last}     o_valid / i_stall
//
// each request is popped in the idle state, then the sequencer steps once per character sent or
// leading zero dropped: character 1-2 steps, eight-digit hex 8, minimal hex 10 (0x and 8 digits)
// decimal adds 32 steps of the shift-add-3 converter before its 10 digit steps
// a two-word queue lets requests be taken while the sequencer is busy
// synchronous active-low reset clears the queue, sequencer and output valid
// a stalled output word holds; the sequencer waits on a full output register
module number_to_ascii_formatter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ntaf_pkg::t_in_word  i_word,
    output logic                o_stall,
    output logic                o_valid,
    output ntaf_pkg::t_out_word o_word,
    input  logic                i_stall
);

    logic            w_task_valid;
    logic            w_task_pop;
    ntaf_pkg::t_task w_task;

    // request intake and queue
    ntaf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_word       (i_word),
        .o_stall      (o_stall),
        .o_task_valid (w_task_valid),
        .o_task       (w_task),
        .i_task_pop   (w_task_pop)
    );

    // character generation
    ntaf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (w_task_valid),
        .i_task       (w_task),
        .o_task_pop   (w_task_pop),
        .o_valid      (o_valid),
        .o_word       (o_word),
        .i_stall      (i_stall)
    );

endmodule

### rtl/core/ntaf_checker.sv
// port-level checks of the number to ascii formatter
`include "assert_macros.svh"

module ntaf_port_checks (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input ntaf_pkg::t_out_word o_word,
    input logic                i_stall
);

    logic w_hold;
    logic w_cr;
    logic w_lf;

    // output word qualifiers
    assign w_hold = o_valid && i_stall;
    assign w_cr   = o_valid && (o_word.ascii_byte == ntaf_pkg::CH_CR);
    assign w_lf   = o_valid && (o_word.ascii_byte == ntaf_pkg::CH_LF);

    // a stalled output word holds
    `ASSERT_SYNC(a_out_hold, i_clk, i_rst_n, w_hold |=> o_valid && $stable(o_word), "held word changed")

    // reset empties the output register
    `ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

    // a carriage return only ever closes a run
    `ASSERT_SYNC(a_cr_last, i_clk, i_rst_n, w_cr |-> o_word.last, "carriage return not last")

    // a line feed never closes a run
    `ASSERT_SYNC(a_lf_not_last, i_clk, i_rst_n, w_lf |-> !o_word.last, "line feed closes a run")

endmodule

bind number_to_ascii_formatter ntaf_port_checks u_chk (.*);
